@@ hw/rtl/fpec_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame peak exposure calibrator package
// Shared widths, reset values, register indexes, verdict codes and the
// beat and configuration types used across the block.
// ----------------------------------------------------------------------------
package fpec_pkg;

    localparam int PIX_W      = 12;
    localparam int TIME_W     = 20;
    localparam int STEP_W     = 8;
    localparam int VERDICT_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Full scale of the converter follows this many sample bits
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [PIX_W-1:0]  RST_UPPER_LIMIT  = PIX_W'(3500);
    localparam logic [PIX_W-1:0]  RST_LOWER_LIMIT  = PIX_W'(2500);
    localparam logic [TIME_W-1:0] RST_MIN_TIME     = TIME_W'(20);
    localparam logic [TIME_W-1:0] RST_MAX_TIME     = TIME_W'(100000);
    localparam logic [TIME_W-1:0] RST_INITIAL_TIME = TIME_W'(1000);
    localparam logic [STEP_W-1:0] RST_MAJOR_STEP   = STEP_W'(20);
    localparam logic [STEP_W-1:0] RST_MINOR_STEP   = STEP_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER_LIMIT  = 3'd0,
        CFG_LOWER_LIMIT  = 3'd1,
        CFG_MIN_TIME     = 3'd2,
        CFG_MAX_TIME     = 3'd3,
        CFG_INITIAL_TIME = 3'd4,
        CFG_MAJOR_STEP   = 3'd5,
        CFG_MINOR_STEP   = 3'd6
    } t_cfg_index;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_IN_BAND   = 3'd0,
        VERDICT_DECREASED = 3'd1,
        VERDICT_INCREASED = 3'd2,
        VERDICT_FAIL_SAT  = 3'd3,
        VERDICT_FAIL_DARK = 3'd4
    } t_verdict;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last_pixel;
    } t_in_beat;

    typedef struct packed {
        logic [TIME_W-1:0] integration_time;
        logic [PIX_W-1:0]  frame_peak;
        t_verdict          verdict;
    } t_out_beat;

    // Register file contents plus the time reload strobe
    typedef struct packed {
        logic [PIX_W-1:0]  upper_limit;
        logic [PIX_W-1:0]  lower_limit;
        logic [TIME_W-1:0] min_time;
        logic [TIME_W-1:0] max_time;
        logic [TIME_W-1:0] initial_time;
        logic [STEP_W-1:0] major_step;
        logic [STEP_W-1:0] minor_step;
        logic              load_time;
    } t_cfg;

endpackage

@@ hw/rtl/fpec_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the limits, time bounds and steps; flags a reload of the time on a
// write to the initial time register.
// ----------------------------------------------------------------------------
module fpec_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [fpec_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [fpec_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output fpec_pkg::t_cfg                   o_cfg
);
    import fpec_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg           = r_cfg;
        n_cfg.load_time = 1'b0;
        if (i_wr_en) begin
            case (i_wr_index)
                CFG_UPPER_LIMIT:  n_cfg.upper_limit = i_wr_data[PIX_W-1:0];
                CFG_LOWER_LIMIT:  n_cfg.lower_limit = i_wr_data[PIX_W-1:0];
                CFG_MIN_TIME:     n_cfg.min_time    = i_wr_data[TIME_W-1:0];
                CFG_MAX_TIME:     n_cfg.max_time    = i_wr_data[TIME_W-1:0];
                CFG_INITIAL_TIME: begin
                    n_cfg.initial_time = i_wr_data[TIME_W-1:0];
                    n_cfg.load_time    = 1'b1;
                end
                CFG_MAJOR_STEP:   n_cfg.major_step  = i_wr_data[STEP_W-1:0];
                CFG_MINOR_STEP:   n_cfg.minor_step  = i_wr_data[STEP_W-1:0];
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upper_limit  <= RST_UPPER_LIMIT;
            r_cfg.lower_limit  <= RST_LOWER_LIMIT;
            r_cfg.min_time     <= RST_MIN_TIME;
            r_cfg.max_time     <= RST_MAX_TIME;
            r_cfg.initial_time <= RST_INITIAL_TIME;
            r_cfg.major_step   <= RST_MAJOR_STEP;
            r_cfg.minor_step   <= RST_MINOR_STEP;
            r_cfg.load_time    <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/fpec_core.sv @@
// ----------------------------------------------------------------------------
// Peak tracker and exposure decision
// Keeps the running frame peak and the integration time; on the last pixel
// of a frame picks the step, applies the bound guards and forms the result.
// ----------------------------------------------------------------------------
module fpec_core #(
    parameter int SAMPLE_BITS = fpec_pkg::SAMPLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  fpec_pkg::t_in_beat   i_beat,
    input  fpec_pkg::t_cfg       i_cfg,
    output logic                 o_res_valid,
    output fpec_pkg::t_out_beat  o_res
);
    import fpec_pkg::*;

    localparam int CMP_W = ((SAMPLE_BITS > PIX_W) ? SAMPLE_BITS : PIX_W) + 2;
    localparam logic [CMP_W-1:0] FULL_SCALE = CMP_W'((1 << SAMPLE_BITS) - 1);

    logic [PIX_W-1:0]  r_peak;
    logic [PIX_W-1:0]  n_peak;
    logic [TIME_W-1:0] r_time;
    logic [TIME_W-1:0] n_time;

    logic [PIX_W-1:0]  peak;
    logic              sat;
    logic              dark;
    logic              sat_major;
    logic              dark_major;
    logic [STEP_W-1:0] step;
    logic [TIME_W:0]   dec_floor;
    logic [TIME_W:0]   inc_sum;
    logic              dec_ok;
    logic              inc_ok;
    t_verdict          verdict;
    logic [TIME_W-1:0] frame_time;

    always_comb begin
        peak = (i_beat.pixel > r_peak) ? i_beat.pixel : r_peak;
        sat  = peak > i_cfg.upper_limit;
        dark = peak < i_cfg.lower_limit;

        // peak - upper >= full - upper reduces to peak >= full
        sat_major  = CMP_W'(peak) >= FULL_SCALE;
        // lower - peak > full - upper, with both sides moved to stay unsigned
        dark_major = (CMP_W'(i_cfg.lower_limit) + CMP_W'(i_cfg.upper_limit))
                     > (FULL_SCALE + CMP_W'(peak));

        if (sat) begin
            step = sat_major ? i_cfg.major_step : i_cfg.minor_step;
        end else begin
            step = dark_major ? i_cfg.major_step : i_cfg.minor_step;
        end

        dec_floor = {1'b0, i_cfg.min_time} + (TIME_W+1)'(step);
        inc_sum   = {1'b0, r_time} + (TIME_W+1)'(step);
        dec_ok    = {1'b0, r_time} >= dec_floor;
        inc_ok    = inc_sum <= {1'b0, i_cfg.max_time};

        frame_time = r_time;
        verdict    = VERDICT_IN_BAND;
        if (sat) begin
            if (dec_ok) begin
                frame_time = r_time - TIME_W'(step);
                verdict    = VERDICT_DECREASED;
            end else begin
                verdict    = VERDICT_FAIL_SAT;
            end
        end else if (dark) begin
            if (inc_ok) begin
                frame_time = inc_sum[TIME_W-1:0];
                verdict    = VERDICT_INCREASED;
            end else begin
                verdict    = VERDICT_FAIL_DARK;
            end
        end

        n_peak = r_peak;
        n_time = r_time;
        if (i_accept) begin
            n_peak = i_beat.last_pixel ? '0 : peak;
            if (i_beat.last_pixel) begin
                n_time = frame_time;
            end
        end
        // reload on an initial time write
        if (i_cfg.load_time) begin
            n_time = i_cfg.initial_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_time <= RST_INITIAL_TIME;
        end else begin
            r_peak <= n_peak;
            r_time <= n_time;
        end
    end

    assign o_res_valid            = i_accept && i_beat.last_pixel;
    assign o_res.integration_time = frame_time;
    assign o_res.frame_peak       = peak;
    assign o_res.verdict          = verdict;

endmodule

@@ hw/rtl/fpec_out_buf.sv @@
// ----------------------------------------------------------------------------
// Result output register with skid stage
// Registers each frame result and parks one more while the sink stalls,
// so the pixel stream keeps flowing until the skid stage is full.
// ----------------------------------------------------------------------------
module fpec_out_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_valid,
    input  fpec_pkg::t_out_beat  i_res,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fpec_pkg::t_out_beat  o_out_data
);
    import fpec_pkg::*;

    logic      r_out_valid;
    logic      n_out_valid;
    logic      r_skid_valid;
    logic      n_skid_valid;
    t_out_beat r_out;
    t_out_beat n_out;
    t_out_beat r_skid;
    t_out_beat n_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        // advance the parked beat
        if (r_skid_valid && !n_out_valid) begin
            n_out        = r_skid;
            n_out_valid  = 1'b1;
            n_skid_valid = 1'b0;
        end
        if (i_res_valid) begin
            if (!n_out_valid) begin
                n_out       = i_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hw/rtl/frame_peak_exposure_calibrator_top.sv @@
// ----------------------------------------------------------------------------
// Frame peak exposure calibrator
// Tracks the peak pixel of each frame and steps the integration time up or
// down at frame end, refusing steps that leave the allowed time range.
//
//   channel | direction | handshake                  | payload
//   in      | sink      | i_in_valid / o_in_ready    | i_in_data  (pixel, last_pixel)
//   out     | source    | o_out_valid / i_out_ready  | o_out_data (time, peak, verdict)
//   cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One pixel is taken every cycle while o_in_ready is high; the peak compare and
// the frame-end decision are combinational ahead of the result register. The
// skid stage holds one extra result while the sink stalls, so o_in_ready
// drops only when two results are waiting on a stalled sink.
// Synchronous active-low reset restores register defaults, clears the peak
// and the result valids; configuration writes are always taken.
// ----------------------------------------------------------------------------
module frame_peak_exposure_calibrator_top #(
    parameter int SAMPLE_BITS = fpec_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  fpec_pkg::t_in_beat               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output fpec_pkg::t_out_beat              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fpec_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fpec_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fpec_pkg::*;

    t_cfg      cfg;
    logic      in_accept;
    logic      res_valid;
    t_out_beat res;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;

    fpec_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    fpec_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_beat      (i_in_data),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    fpec_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
